FILE: rtl/ieval_pkg.sv
// ----------------------------------------------------------------------------
// ieval_pkg
// Shared types, codes and helpers for the infix expression evaluator.
// ----------------------------------------------------------------------------
package ieval_pkg;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned PREC_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

    // operator codes as held on the operator stack
    localparam logic [OP_W-1:0] OP_OPEN = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_W-1:0] OP_POW  = 3'd5;

    localparam logic [PREC_W-1:0] PREC_NONE = 3'd0;
    localparam logic [PREC_W-1:0] PREC_OPEN = 3'd1;
    localparam logic [PREC_W-1:0] PREC_ADD  = 3'd2;
    localparam logic [PREC_W-1:0] PREC_MUL  = 3'd3;
    localparam logic [PREC_W-1:0] PREC_POW  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV0 = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVFL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MALF = 2'd3;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2a;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5e;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_Y     = 8'h79;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        CLS_START = 2'd0,
        CLS_OPER  = 2'd1,
        CLS_OPEN  = 2'd2,
        CLS_OTHER = 2'd3
    } cls_t;

    typedef enum logic [2:0] {
        K_DIGIT = 3'd0,
        K_MINUS = 3'd1,
        K_BINOP = 3'd2,
        K_OPEN  = 3'd3,
        K_CLOSE = 3'd4,
        K_VARX  = 3'd5,
        K_VARY  = 3'd6,
        K_OTHER = 3'd7
    } kind_t;

    typedef struct packed {
        logic                load_in;
        logic                acc_digit;
        logic                push_acc;
        logic                push_x;
        logic                push_y;
        logic                push_res;
        logic                set_neg;
        logic                prev_we;
        cls_t                prev;
        logic                minprec_we;
        logic [PREC_W-1:0]   minprec;
        logic                push_op;
        logic                op_rd;
        logic                op_pop;
        logic                rd_top1;
        logic                rd_top2;
        logic                rd_base;
        logic                latch_b;
        logic                latch_a;
        logic                alu_start;
        logic                raise;
        logic [STATUS_W-1:0] raise_code;
        logic                close;
        logic                emit;
        logic                clear_all;
    } dp_cmd_t;

    typedef struct packed {
        logic              err;
        logic              last;
        kind_t             kind;
        logic [PREC_W-1:0] char_prec;
        logic              nip;
        logic              prev_other;
        logic              otop_zero;
        logic              pop_ok;
        logic              op_bad;
        logic              vtop_lt2;
        logic              div_zero;
        logic              final_bad;
        logic              alu_done;
        logic              out_busy;
    } dp_stat_t;

    function automatic logic [PREC_W-1:0] prec_of(input logic [OP_W-1:0] op);
        logic [PREC_W-1:0] p;
        p = PREC_POW;
        if (op == OP_OPEN)
            p = PREC_OPEN;
        else if (op == OP_ADD || op == OP_SUB)
            p = PREC_ADD;
        else if (op == OP_MUL || op == OP_DIV)
            p = PREC_MUL;
        return p;
    endfunction

endpackage

FILE: rtl/ieval_ram.sv
// ----------------------------------------------------------------------------
// ieval_ram
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
module ieval_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ieval_alu.sv
// ----------------------------------------------------------------------------
// ieval_alu
// Multi-cycle arithmetic unit: add, subtract, 4-bit-a-cycle multiply,
// restoring divide and square-and-multiply power, all wrapping at 64 bits.
// ----------------------------------------------------------------------------
module ieval_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ieval_pkg::OP_W-1:0]    op,
    input  logic [ieval_pkg::DATA_W-1:0]  a,
    input  logic [ieval_pkg::DATA_W-1:0]  b,
    output logic                          done,
    output logic [ieval_pkg::DATA_W-1:0]  result
);

    localparam int unsigned W = ieval_pkg::DATA_W;

    typedef enum logic [5:0] {
        AL_IDLE = 6'b000001,
        AL_MUL  = 6'b000010,
        AL_DIV  = 6'b000100,
        AL_DFIX = 6'b001000,
        AL_POW  = 6'b010000,
        AL_DONE = 6'b100000
    } al_state_t;

    typedef enum logic [1:0] {
        D_RES  = 2'd0,
        D_POWR = 2'd1,
        D_POWB = 2'd2
    } mdst_t;

    al_state_t state_reg, state_next;
    mdst_t     dst_reg, dst_next;
    logic [W-1:0] res_reg, res_next;
    logic [W-1:0] base_reg, base_next;
    logic [W-1:0] exp_reg, exp_next;
    logic [W-1:0] mx_reg, mx_next;
    logic [W-1:0] my_reg, my_next;
    logic [W-1:0] mp_reg, mp_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] q_reg, q_next;
    logic [W-1:0] mb_reg, mb_next;
    logic         neg_reg, neg_next;
    logic [ieval_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [W:0]   div_sh;
    logic [W:0]   div_t;
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;

    assign mag_a  = a[W-1] ? (W'(0) - a) : a;
    assign mag_b  = b[W-1] ? (W'(0) - b) : b;
    assign div_sh = {rem_reg, q_reg[W-1]};
    assign div_t  = div_sh - {1'b0, mb_reg};

    always_comb
    begin
        state_next = state_reg;
        dst_next   = dst_reg;
        res_next   = res_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        mp_next    = mp_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            AL_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        ieval_pkg::OP_ADD:
                        begin
                            res_next   = a + b;
                            state_next = AL_DONE;
                        end
                        ieval_pkg::OP_SUB:
                        begin
                            res_next   = a - b;
                            state_next = AL_DONE;
                        end
                        ieval_pkg::OP_MUL:
                        begin
                            mx_next    = a;
                            my_next    = b;
                            mp_next    = '0;
                            dst_next   = D_RES;
                            state_next = AL_MUL;
                        end
                        ieval_pkg::OP_DIV:
                        begin
                            rem_next   = '0;
                            q_next     = mag_a;
                            mb_next    = mag_b;
                            neg_next   = a[W-1] ^ b[W-1];
                            cnt_next   = '0;
                            state_next = AL_DIV;
                        end
                        default:
                        begin
                            if (b[W-1])
                            begin
                                res_next   = '0;
                                state_next = AL_DONE;
                            end
                            else
                            begin
                                res_next   = W'(1);
                                base_next  = a;
                                exp_next   = b;
                                state_next = AL_POW;
                            end
                        end
                    endcase
                end
            end
            AL_MUL:
            begin
                if (my_reg == '0)
                begin
                    case (dst_reg)
                        D_POWR:
                        begin
                            res_next = mp_reg;
                            mx_next  = base_reg;
                            my_next  = base_reg;
                            mp_next  = '0;
                            dst_next = D_POWB;
                        end
                        D_POWB:
                        begin
                            base_next  = mp_reg;
                            exp_next   = exp_reg >> 1;
                            state_next = AL_POW;
                        end
                        default:
                        begin
                            res_next   = mp_reg;
                            state_next = AL_DONE;
                        end
                    endcase
                end
                else
                begin
                    mp_next = mp_reg + mx_reg * {{(W-4){1'b0}}, my_reg[3:0]};
                    mx_next = mx_reg << 4;
                    my_next = my_reg >> 4;
                end
            end
            AL_DIV:
            begin
                if (!div_t[W])
                begin
                    rem_next = div_t[W-1:0];
                    q_next   = {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_sh[W-1:0];
                    q_next   = {q_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = AL_DFIX;
                end
            end
            AL_DFIX:
            begin
                res_next   = neg_reg ? (W'(0) - q_reg) : q_reg;
                state_next = AL_DONE;
            end
            AL_POW:
            begin
                if (exp_reg == '0)
                begin
                    state_next = AL_DONE;
                end
                else
                begin
                    mp_next    = '0;
                    state_next = AL_MUL;
                    if (exp_reg[0])
                    begin
                        mx_next  = res_reg;
                        my_next  = base_reg;
                        dst_next = D_POWR;
                    end
                    else
                    begin
                        mx_next  = base_reg;
                        my_next  = base_reg;
                        dst_next = D_POWB;
                    end
                end
            end
            AL_DONE:
            begin
                state_next = AL_IDLE;
            end
            default:
            begin
                state_next = AL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg  <= dst_next;
        res_reg  <= res_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        mp_reg   <= mp_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
    end

    assign done   = (state_reg == AL_DONE);
    assign result = res_reg;

endmodule

FILE: rtl/ieval_datapath.sv
// ----------------------------------------------------------------------------
// ieval_datapath
// Registers, both stacks, number accumulator, arithmetic unit and the
// output register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module ieval_datapath #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ieval_pkg::dp_cmd_t                cmd,
    output ieval_pkg::dp_stat_t               stat,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [ieval_pkg::DATA_W-1:0]      cfg_data,
    input  logic [ieval_pkg::CHAR_W-1:0]      in_char,
    input  logic                              in_last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ieval_pkg::DATA_W-1:0]      out_value,
    output logic [ieval_pkg::STATUS_W-1:0]    out_status
);

    localparam int unsigned W  = ieval_pkg::DATA_W;
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned TW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned OW = ieval_pkg::OP_W;

    logic [W-1:0]                    x_reg, x_next;
    logic [W-1:0]                    y_reg, y_next;
    logic [ieval_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                            last_reg, last_next;
    logic [W-1:0]                    acc_reg, acc_next;
    logic                            nip_reg, nip_next;
    logic                            pend_reg, pend_next;
    ieval_pkg::cls_t                 prev_reg, prev_next;
    logic [ieval_pkg::STATUS_W-1:0]  err_reg, err_next;
    logic [TW-1:0]                   vtop_reg, vtop_next;
    logic [TW-1:0]                   otop_reg, otop_next;
    logic [ieval_pkg::PREC_W-1:0]    minprec_reg, minprec_next;
    logic [OW-1:0]                   cur_op_reg, cur_op_next;
    logic [W-1:0]                    a_reg, a_next;
    logic [W-1:0]                    b_reg, b_next;
    logic                            out_valid_reg, out_valid_next;
    logic [W-1:0]                    out_value_reg, out_value_next;
    logic [ieval_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;

    ieval_pkg::kind_t                kind;
    logic [OW-1:0]                   char_op;
    logic [ieval_pkg::PREC_W-1:0]    char_prec;

    logic [W-1:0]  operand;
    logic [W-1:0]  operand_s;
    logic          vpush;
    logic          vfull;
    logic          ofull;
    logic          do_vwrite;
    logic          do_owrite;
    logic [W-1:0]  vwdata;
    logic          v_re;
    logic [TW-1:0] vraddr_t;
    logic [W-1:0]  v_rdata;
    logic [OW-1:0] o_rdata;
    logic [TW-1:0] otop_m1;
    logic          alu_done;
    logic [W-1:0]  alu_res;
    logic          out_busy;
    logic          no_err;

    // character decode
    always_comb
    begin
        kind      = ieval_pkg::K_OTHER;
        char_op   = ieval_pkg::OP_OPEN;
        char_prec = ieval_pkg::PREC_NONE;
        case (char_reg) inside
            [ieval_pkg::CH_ZERO:ieval_pkg::CH_NINE]:
            begin
                kind = ieval_pkg::K_DIGIT;
            end
            ieval_pkg::CH_MINUS:
            begin
                kind      = ieval_pkg::K_MINUS;
                char_op   = ieval_pkg::OP_SUB;
                char_prec = ieval_pkg::PREC_ADD;
            end
            ieval_pkg::CH_PLUS:
            begin
                kind      = ieval_pkg::K_BINOP;
                char_op   = ieval_pkg::OP_ADD;
                char_prec = ieval_pkg::PREC_ADD;
            end
            ieval_pkg::CH_STAR:
            begin
                kind      = ieval_pkg::K_BINOP;
                char_op   = ieval_pkg::OP_MUL;
                char_prec = ieval_pkg::PREC_MUL;
            end
            ieval_pkg::CH_SLASH:
            begin
                kind      = ieval_pkg::K_BINOP;
                char_op   = ieval_pkg::OP_DIV;
                char_prec = ieval_pkg::PREC_MUL;
            end
            ieval_pkg::CH_CARET:
            begin
                kind      = ieval_pkg::K_BINOP;
                char_op   = ieval_pkg::OP_POW;
                char_prec = ieval_pkg::PREC_POW;
            end
            ieval_pkg::CH_OPEN:
            begin
                kind = ieval_pkg::K_OPEN;
            end
            ieval_pkg::CH_CLOSE:
            begin
                kind = ieval_pkg::K_CLOSE;
            end
            ieval_pkg::CH_X:
            begin
                kind = ieval_pkg::K_VARX;
            end
            ieval_pkg::CH_Y:
            begin
                kind = ieval_pkg::K_VARY;
            end
            default:
            begin
                kind = ieval_pkg::K_OTHER;
            end
        endcase
    end

    assign no_err    = (err_reg == ieval_pkg::ST_OK);
    assign operand   = cmd.push_acc ? acc_reg : (cmd.push_x ? x_reg : y_reg);
    assign operand_s = pend_reg ? (W'(0) - operand) : operand;
    assign vpush     = cmd.push_acc | cmd.push_x | cmd.push_y | cmd.push_res;
    assign vfull     = (vtop_reg >= TW'(STACK_DEPTH));
    assign ofull     = (otop_reg >= TW'(STACK_DEPTH));
    assign do_vwrite = vpush && no_err && !vfull;
    assign do_owrite = cmd.push_op && no_err && !ofull;
    assign vwdata    = cmd.push_res ? alu_res : operand_s;
    assign otop_m1   = otop_reg - TW'(1);
    assign v_re      = cmd.rd_top1 | cmd.rd_top2 | cmd.rd_base;
    assign out_busy  = out_valid_reg && !out_ready;

    always_comb
    begin
        if (cmd.rd_top1)
            vraddr_t = vtop_reg - TW'(1);
        else if (cmd.rd_top2)
            vraddr_t = vtop_reg - TW'(2);
        else
            vraddr_t = '0;
    end

    always_comb
    begin
        x_next          = x_reg;
        y_next          = y_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        acc_next        = acc_reg;
        nip_next        = nip_reg;
        pend_next       = pend_reg;
        prev_next       = prev_reg;
        err_next        = err_reg;
        vtop_next       = vtop_reg;
        otop_next       = otop_reg;
        minprec_next    = minprec_reg;
        cur_op_next     = cur_op_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        if (cfg_we)
        begin
            if (cfg_index)
                y_next = cfg_data;
            else
                x_next = cfg_data;
        end
        if (cmd.load_in)
        begin
            char_next = in_char;
            last_next = in_last;
        end
        if (cmd.acc_digit)
        begin
            acc_next  = (acc_reg << 3) + (acc_reg << 1) + {{(W-4){1'b0}}, char_reg[3:0]};
            nip_next  = 1'b1;
            prev_next = ieval_pkg::CLS_OTHER;
        end
        if (cmd.push_acc)
        begin
            acc_next = '0;
            nip_next = 1'b0;
        end
        if (cmd.push_acc || cmd.push_x || cmd.push_y)
        begin
            pend_next = 1'b0;
            prev_next = ieval_pkg::CLS_OTHER;
        end
        if (cmd.set_neg)
        begin
            pend_next = 1'b1;
            prev_next = ieval_pkg::CLS_OPER;
        end
        if (cmd.prev_we)
        begin
            prev_next = cmd.prev;
        end
        if (cmd.minprec_we)
        begin
            minprec_next = cmd.minprec;
        end
        if (do_vwrite)
        begin
            vtop_next = vtop_reg + TW'(1);
        end
        if (cmd.latch_a)
        begin
            vtop_next = vtop_reg - TW'(2);
            a_next    = v_rdata;
        end
        if (cmd.latch_b)
        begin
            b_next = v_rdata;
        end
        if (do_owrite)
        begin
            otop_next = otop_reg + TW'(1);
        end
        if (cmd.op_pop || cmd.close)
        begin
            otop_next = otop_m1;
        end
        if (cmd.op_pop)
        begin
            cur_op_next = o_rdata;
        end
        if (no_err)
        begin
            if (vpush && vfull)
                err_next = ieval_pkg::ST_OVFL;
            else if (cmd.push_op && ofull)
                err_next = ieval_pkg::ST_OVFL;
            else if (cmd.raise)
                err_next = cmd.raise_code;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = no_err ? v_rdata : '0;
            out_status_next = err_reg;
        end
        if (cmd.clear_all)
        begin
            vtop_next = '0;
            otop_next = '0;
            pend_next = 1'b0;
            acc_next  = '0;
            nip_next  = 1'b0;
            prev_next = ieval_pkg::CLS_START;
            err_next  = ieval_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            y_reg         <= '0;
            acc_reg       <= '0;
            nip_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            prev_reg      <= ieval_pkg::CLS_START;
            err_reg       <= ieval_pkg::ST_OK;
            vtop_reg      <= '0;
            otop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            acc_reg       <= acc_next;
            nip_reg       <= nip_next;
            pend_reg      <= pend_next;
            prev_reg      <= prev_next;
            err_reg       <= err_next;
            vtop_reg      <= vtop_next;
            otop_reg      <= otop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg       <= char_next;
        last_reg       <= last_next;
        minprec_reg    <= minprec_next;
        cur_op_reg     <= cur_op_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    ieval_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_value_stack (
        .clk   (clk),
        .we    (do_vwrite),
        .waddr (vtop_reg[AW-1:0]),
        .wdata (vwdata),
        .re    (v_re),
        .raddr (vraddr_t[AW-1:0]),
        .rdata (v_rdata)
    );

    ieval_ram #(
        .WIDTH (OW),
        .DEPTH (STACK_DEPTH)
    ) u_operator_stack (
        .clk   (clk),
        .we    (do_owrite),
        .waddr (otop_reg[AW-1:0]),
        .wdata (char_op),
        .re    (cmd.op_rd),
        .raddr (otop_m1[AW-1:0]),
        .rdata (o_rdata)
    );

    ieval_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.alu_start),
        .op     (cur_op_reg),
        .a      (a_reg),
        .b      (b_reg),
        .done   (alu_done),
        .result (alu_res)
    );

    always_comb
    begin
        stat.err        = !no_err;
        stat.last       = last_reg;
        stat.kind       = kind;
        stat.char_prec  = char_prec;
        stat.nip        = nip_reg;
        stat.prev_other = (prev_reg == ieval_pkg::CLS_OTHER);
        stat.otop_zero  = (otop_reg == '0);
        stat.pop_ok     = (ieval_pkg::prec_of(o_rdata) >= minprec_reg);
        stat.op_bad     = (o_rdata == ieval_pkg::OP_OPEN) || (o_rdata > ieval_pkg::OP_POW);
        stat.vtop_lt2   = (vtop_reg < TW'(2));
        stat.div_zero   = (cur_op_reg == ieval_pkg::OP_DIV) && (b_reg == '0);
        stat.final_bad  = (vtop_reg != TW'(1)) || pend_reg;
        stat.alu_done   = alu_done;
        stat.out_busy   = out_busy;
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

FILE: rtl/ieval_ctrl.sv
// ----------------------------------------------------------------------------
// ieval_ctrl
// Sequencer: character dispatch, operator reduction loop and final result.
// ----------------------------------------------------------------------------
module ieval_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ieval_pkg::dp_stat_t  stat,
    output ieval_pkg::dp_cmd_t   cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_DISP    = 13'b0000000000010,
        S_CHAR    = 13'b0000000000100,
        S_RED_RD  = 13'b0000000001000,
        S_RED_CHK = 13'b0000000010000,
        S_RD_B    = 13'b0000000100000,
        S_RD_A    = 13'b0000001000000,
        S_EXEC    = 13'b0000010000000,
        S_ALU     = 13'b0000100000000,
        S_AFTER   = 13'b0001000000000,
        S_FIN     = 13'b0010000000000,
        S_FIN_CHK = 13'b0100000000000,
        S_FIN_RD  = 13'b1000000000000
    } state_t;

    typedef enum logic [1:0] {
        RET_PUSHOP = 2'd0,
        RET_CLOSE  = 2'd1,
        RET_FINAL  = 2'd2
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;
    state_t char_done;

    assign char_done = stat.last ? S_FIN : S_IDLE;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.err)
                begin
                    state_next = char_done;
                end
                else if (stat.kind == ieval_pkg::K_DIGIT)
                begin
                    cmd.acc_digit = 1'b1;
                    state_next    = char_done;
                end
                else
                begin
                    cmd.push_acc = stat.nip;
                    state_next   = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (stat.err)
                begin
                    state_next = char_done;
                end
                else
                begin
                    state_next = char_done;
                    case (stat.kind)
                        ieval_pkg::K_MINUS:
                        begin
                            if (!stat.prev_other)
                            begin
                                cmd.set_neg = 1'b1;
                            end
                            else
                            begin
                                cmd.minprec_we = 1'b1;
                                cmd.minprec    = stat.char_prec;
                                ret_next       = RET_PUSHOP;
                                state_next     = S_RED_RD;
                            end
                        end
                        ieval_pkg::K_BINOP:
                        begin
                            cmd.minprec_we = 1'b1;
                            cmd.minprec    = stat.char_prec;
                            ret_next       = RET_PUSHOP;
                            state_next     = S_RED_RD;
                        end
                        ieval_pkg::K_OPEN:
                        begin
                            cmd.push_op = 1'b1;
                            cmd.prev_we = 1'b1;
                            cmd.prev    = ieval_pkg::CLS_OPEN;
                        end
                        ieval_pkg::K_CLOSE:
                        begin
                            cmd.minprec_we = 1'b1;
                            cmd.minprec    = ieval_pkg::PREC_ADD;
                            ret_next       = RET_CLOSE;
                            state_next     = S_RED_RD;
                        end
                        ieval_pkg::K_VARX:
                        begin
                            cmd.push_x = 1'b1;
                        end
                        ieval_pkg::K_VARY:
                        begin
                            cmd.push_y = 1'b1;
                        end
                        default:
                        begin
                            cmd.prev_we = 1'b1;
                            cmd.prev    = ieval_pkg::CLS_OTHER;
                        end
                    endcase
                end
            end
            S_RED_RD:
            begin
                if (stat.err || stat.otop_zero)
                begin
                    state_next = S_AFTER;
                end
                else
                begin
                    cmd.op_rd  = 1'b1;
                    state_next = S_RED_CHK;
                end
            end
            S_RED_CHK:
            begin
                if (!stat.pop_ok)
                begin
                    state_next = S_AFTER;
                end
                else
                begin
                    cmd.op_pop = 1'b1;
                    if (stat.op_bad || stat.vtop_lt2)
                    begin
                        cmd.raise      = 1'b1;
                        cmd.raise_code = ieval_pkg::ST_MALF;
                        state_next     = S_RED_RD;
                    end
                    else
                    begin
                        cmd.rd_top1 = 1'b1;
                        state_next  = S_RD_B;
                    end
                end
            end
            S_RD_B:
            begin
                cmd.latch_b = 1'b1;
                cmd.rd_top2 = 1'b1;
                state_next  = S_RD_A;
            end
            S_RD_A:
            begin
                cmd.latch_a = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.div_zero)
                begin
                    cmd.raise      = 1'b1;
                    cmd.raise_code = ieval_pkg::ST_DIV0;
                    state_next     = S_RED_RD;
                end
                else
                begin
                    cmd.alu_start = 1'b1;
                    state_next    = S_ALU;
                end
            end
            S_ALU:
            begin
                if (stat.alu_done)
                begin
                    cmd.push_res = 1'b1;
                    state_next   = S_RED_RD;
                end
            end
            S_AFTER:
            begin
                case (ret_reg)
                    RET_PUSHOP:
                    begin
                        cmd.push_op = 1'b1;
                        cmd.prev_we = 1'b1;
                        cmd.prev    = ieval_pkg::CLS_OPER;
                        state_next  = char_done;
                    end
                    RET_CLOSE:
                    begin
                        if (!stat.err)
                        begin
                            if (stat.otop_zero)
                            begin
                                cmd.raise      = 1'b1;
                                cmd.raise_code = ieval_pkg::ST_MALF;
                            end
                            else
                            begin
                                cmd.close = 1'b1;
                            end
                        end
                        cmd.prev_we = 1'b1;
                        cmd.prev    = ieval_pkg::CLS_OTHER;
                        state_next  = char_done;
                    end
                    default:
                    begin
                        state_next = S_FIN_CHK;
                    end
                endcase
            end
            S_FIN:
            begin
                cmd.push_acc   = stat.nip;
                cmd.minprec_we = 1'b1;
                cmd.minprec    = ieval_pkg::PREC_NONE;
                ret_next       = RET_FINAL;
                state_next     = S_RED_RD;
            end
            S_FIN_CHK:
            begin
                if (!stat.err && stat.final_bad)
                begin
                    cmd.raise      = 1'b1;
                    cmd.raise_code = ieval_pkg::ST_MALF;
                end
                cmd.rd_base = 1'b1;
                state_next  = S_FIN_RD;
            end
            S_FIN_RD:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.clear_all = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_PUSHOP;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

FILE: rtl/infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Evaluates an infix expression streamed one ASCII character per request.
// ----------------------------------------------------------------------------
// Characters arrive on the slave stream, tlast marking the end of the
// expression; one result (64-bit value and 2-bit status) leaves on the master
// stream per expression. One character is taken at a time: a digit is
// accumulated into the number, a bracket-open, a variable or an ignored
// character is handled without reduction, and an operator or a closing
// bracket pops operators from the operator stack, each through the shared
// arithmetic unit (add/sub, multiply, divide, power). The final character
// also pops the remaining operators. The stacks are memories with one read
// port, which sets the per-operator cost; no clearing pass is needed.
// The user must write x_value and y_value through the cfg port only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] value, [65:64] status
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    ieval_pkg::dp_cmd_t  cmd;
    ieval_pkg::dp_stat_t stat;
    logic [ieval_pkg::DATA_W-1:0]   value;
    logic [ieval_pkg::STATUS_W-1:0] status;

    ieval_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ieval_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_char    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (value),
        .out_status (status)
    );

    assign m_axis_tdata = {6'b0, status, value};

endmodule
